@@ rtl/core/mrm_pkg.sv @@
`default_nettype none

package mrm_pkg;

   localparam int DIM       = 4;
   localparam int ELEM_W    = 32;
   localparam int ROW_W     = 2;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int PAYLOAD_W = ROW_W + DIM * ELEM_W;
   localparam int DATA_W    = ((PAYLOAD_W + 7) / 8) * 8;
   localparam int PAD_W     = DATA_W - PAYLOAD_W;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic [ROW_W-1:0]         row_type;

   localparam elem_type ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_MUL  = 1'b1
   } command_type;

   // Load enables of the three lane pipeline stages.
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
   } lane_ctl_type;

endpackage

`default_nettype wire

@@ rtl/core/mrm_lane.sv @@
`default_nettype none

// One output column: four products, a pair of adds, then the final add with
// shift and saturation.
module mrm_lane
   import mrm_pkg::*;
(
   input  wire logic         clock,
   input  lane_ctl_type      ctl,
   input  elem_type          a_row [DIM],
   input  elem_type          b_col [DIM],
   output elem_type          res,
   output logic              ovf
);

   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic signed [PROD_W-1:0] prod_in [DIM];
   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [PAIR_W-1:0] pair_in [2];
   elem_type                 res_ff;
   elem_type                 res_in;
   logic                     ovf_ff;
   logic                     ovf_in;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  shifted;
   logic [SUM_W-ELEM_W:0]    upper;

   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         prod_in[k] = a_row[k] * b_col[k];
      end
      pair_in[0] = {prod_ff[0][PROD_W-1], prod_ff[0]} + {prod_ff[1][PROD_W-1], prod_ff[1]};
      pair_in[1] = {prod_ff[2][PROD_W-1], prod_ff[2]} + {prod_ff[3][PROD_W-1], prod_ff[3]};
   end

   // The result fits when every bit from the sign position upward agrees.
   always_comb begin
      sum     = {pair_ff[0][PAIR_W-1], pair_ff[0]} + {pair_ff[1][PAIR_W-1], pair_ff[1]};
      shifted = sum >>> FRAC_BITS;
      upper   = shifted[SUM_W-1:ELEM_W-1];
      if ((&upper) || !(|upper)) begin
         res_in = shifted[ELEM_W-1:0];
         ovf_in = 1'b0;
      end else begin
         res_in = shifted[SUM_W-1] ? ELEM_MIN : ELEM_MAX;
         ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld1) begin
         prod_ff <= prod_in;
      end
      if (ctl.ld2) begin
         pair_ff <= pair_in;
      end
      if (ctl.ld3) begin
         res_ff <= res_in;
         ovf_ff <= ovf_in;
      end
   end

   assign res = res_ff;
   assign ovf = ovf_ff;

endmodule

`default_nettype wire

@@ rtl/core/mrm_merge.sv @@
`default_nettype none

// Output register: gathers the lane results into one row and folds the
// lane overflow flags together.
module mrm_merge
   import mrm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire logic            lane_valid,
   input  row_type              lane_row,
   input  elem_type             lane_res [DIM],
   input  wire logic [DIM-1:0]  lane_ovf,
   output logic                 rsp_tvalid,
   output logic [DATA_W-1:0]    rsp_tdata,
   output logic                 rsp_tuser
);

   logic                valid_ff;
   logic                valid_in;
   logic [DATA_W-1:0]   data_ff;
   logic [DATA_W-1:0]   data_in;
   logic                ovf_ff;
   logic                ovf_in;

   always_comb begin
      valid_in = load ? lane_valid : valid_ff;
      data_in  = {{PAD_W{1'b0}}, lane_res[3], lane_res[2], lane_res[1], lane_res[0],
                  lane_row};
      ovf_in   = |lane_ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load && lane_valid) begin
         data_ff <= data_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = ovf_ff;

endmodule

`default_nettype wire

@@ rtl/core/matrix4x4_row_multiply.sv @@
`default_nettype none

// Row-at-a-time 4x4 matrix product in signed Q16.16.
// The req_ channel carries one row per transfer. With req_tuser at load the
// row is written into row row_index of the right-hand matrix and no result
// follows. With req_tuser at multiply the row is taken as a row of the left
// matrix and one result row with the same index comes back on rsp_.
// Each result column is the exact sum of four products, shifted right by
// 16 bits (toward minus infinity) and saturated; rsp_tuser flags a row in
// which any column saturated.
// A multiply row passes each lane's product register and two adder levels,
// then the output register. One item can be accepted every cycle while the
// receiver keeps up; four column lanes of four multipliers work side by side.
// A load takes effect for a multiply accepted in the very next cycle.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// req_tready drops only once every stage holds a row. Reset empties the
// pipeline; the stored matrix rows are not cleared and must be loaded
// before they are used.
module matrix4x4_row_multiply
   import mrm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // tdata: row_index[1:0], elem0, elem1, elem2, elem3, zero padding.
   input  wire logic [DATA_W-1:0] req_tdata,
   // tuser: command.
   input  wire logic              req_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // tdata: out_row[1:0], res0, res1, res2, res3, zero padding.
   output logic [DATA_W-1:0]      rsp_tdata,
   // tuser: overflow.
   output logic                   rsp_tuser
);

   elem_type      in_elem [DIM];
   row_type       in_row;
   command_type   in_cmd;
   logic          accept;

   // Right-hand matrix storage, indexed [row][column].
   elem_type      b_ff [DIM][DIM];

   logic          v1_ff, v2_ff, v3_ff;
   logic          v1_in, v2_in, v3_in;
   row_type       row1_ff, row2_ff, row3_ff;
   logic          out_free;
   lane_ctl_type  ctl;

   elem_type         lane_res [DIM];
   logic [DIM-1:0]   lane_ovf;

   always_comb begin
      in_row = req_tdata[ROW_W-1:0];
      for (int k = 0; k < DIM; k++) begin
         in_elem[k] = req_tdata[ROW_W + k*ELEM_W +: ELEM_W];
      end
      in_cmd = command_type'(req_tuser);
   end

   // A stage takes new contents when it is empty or its contents move on.
   always_comb begin
      out_free   = !rsp_tvalid || rsp_tready;
      ctl.ld3    = !v3_ff || out_free;
      ctl.ld2    = !v2_ff || ctl.ld3;
      ctl.ld1    = !v1_ff || ctl.ld2;
      req_tready = ctl.ld1;
      accept     = req_tvalid && req_tready;
      v1_in      = ctl.ld1 ? (accept && (in_cmd == CMD_MUL)) : v1_ff;
      v2_in      = ctl.ld2 ? v1_ff : v2_ff;
      v3_in      = ctl.ld3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      if (ctl.ld1) begin
         row1_ff <= in_row;
      end
      if (ctl.ld2) begin
         row2_ff <= row1_ff;
      end
      if (ctl.ld3) begin
         row3_ff <= row2_ff;
      end
      if (accept && (in_cmd == CMD_LOAD)) begin
         b_ff[in_row] <= in_elem;
      end
   end

   for (genvar j = 0; j < DIM; j++) begin : g_lane
      elem_type b_col [DIM];

      always_comb begin
         for (int k = 0; k < DIM; k++) begin
            b_col[k] = b_ff[k][j];
         end
      end

      mrm_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .a_row (in_elem),
         .b_col (b_col),
         .res   (lane_res[j]),
         .ovf   (lane_ovf[j])
      );
   end

   mrm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (out_free),
      .lane_valid (v3_ff),
      .lane_row   (row3_ff),
      .lane_res   (lane_res),
      .lane_ovf   (lane_ovf),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none

// Self-checking bench for the row-at-a-time 4x4 Q16.16 matrix product.
//
// The bench keeps its own copy of the right-hand matrix and, for every
// multiply row it hands to the block, works out the output row it must get
// back: four exact products summed at 66 bits, shifted right by the fraction
// width with truncation toward minus infinity, then clamped to 32 bits with
// the overflow flag raised on any clamp. Load rows only update that copy.
//
// One initial block runs the named tests in turn. All of them push rows
// through send_row, which drives the request side at the falling edge and
// waits for the transfer at the rising edge. A separate process samples the
// response side at the rising edge and compares each result row, field by
// field, with the oldest predicted row. Both sides pause at random between
// transfers, and some phases run flat out, so that gaps land on every
// pipeline stage. The stored matrix is never read before all four of its
// rows have been loaded, because the block does not clear it at reset.
module tb_top;
   import mrm_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ROWS  = 1430;
   localparam int DRAIN_CYCLES = 16;

   localparam logic signed [SUM_W-1:0] SUM_MAX = ELEM_MAX;
   localparam logic signed [SUM_W-1:0] SUM_MIN = ELEM_MIN;

   // How a side spaces its transfers: never waits, may wait before every
   // transfer, or waits only now and then.
   typedef enum logic [1:0] {
      PACE_BURST,
      PACE_SLOW,
      PACE_MIXED
   } pace_type;

   typedef struct packed {
      row_type               row;
      elem_type [DIM-1:0]    col;
      logic                  ovf;
   } product_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tuser;

   // The bench's copy of the right-hand matrix, entry r*4+c holds B[r][c].
   elem_type          right_rows [DIM*DIM];
   logic [DIM-1:0]    rows_loaded = '0;

   product_row_type   expected_rows [$];

   pace_type          req_pace = PACE_MIXED;
   pace_type          rsp_pace = PACE_MIXED;
   int                rsp_stall_left = 0;
   logic              rsp_took = 1'b0;

   int                mismatches = 0;
   int                cycle_count = 0;
   int                loads_sent = 0;
   int                multiplies_sent = 0;
   int                rows_checked = 0;
   int                rows_saturated = 0;

   matrix4x4_row_multiply DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A run that stalls for good ends here instead of hanging.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d rows still outstanding",
                  cycle_count, expected_rows.size());
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int draw_wait(pace_type pace);
      case (pace)
         PACE_BURST: return 0;
         PACE_SLOW:  return $urandom_range(0, 13);
         default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      endcase
   endfunction

   // Expected output row for one row of the left matrix against the
   // current contents of the stored right-hand matrix.
   function automatic product_row_type predict_product_row(row_type r,
                                                           elem_type [DIM-1:0] a);
      product_row_type            res;
      logic signed [SUM_W-1:0]    acc;
      logic signed [SUM_W-1:0]    wa;
      logic signed [SUM_W-1:0]    wb;
      logic signed [SUM_W-1:0]    shifted;
      res.row = r;
      res.ovf = 1'b0;
      for (int j = 0; j < DIM; j++) begin
         acc = '0;
         for (int k = 0; k < DIM; k++) begin
            wa  = $signed(a[k]);
            wb  = $signed(right_rows[k*DIM + j]);
            acc = acc + wa * wb;
         end
         shifted = acc >>> FRAC_BITS;
         if (shifted > SUM_MAX) begin
            res.col[j] = ELEM_MAX;
            res.ovf    = 1'b1;
         end else if (shifted < SUM_MIN) begin
            res.col[j] = ELEM_MIN;
            res.ovf    = 1'b1;
         end else begin
            res.col[j] = shifted[ELEM_W-1:0];
         end
      end
      return res;
   endfunction

   // Sends one row. Entered and left at a falling edge; the row is taken
   // into the prediction at the rising edge where the transfer happens.
   task automatic send_row(command_type cmd, row_type r,
                           elem_type e0, elem_type e1, elem_type e2, elem_type e3);
      elem_type [DIM-1:0] e;
      logic [DATA_W-1:0]  d;
      int                 gap;
      e   = {e3, e2, e1, e0};
      gap = draw_wait(req_pace);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      d = '0;
      d[ROW_W-1:0] = r;
      for (int j = 0; j < DIM; j++) begin
         d[ROW_W + ELEM_W*j +: ELEM_W] = e[j];
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= cmd;
      do begin
         @(posedge clock);
      end while (!req_tready);
      if (cmd == CMD_LOAD) begin
         for (int k = 0; k < DIM; k++) begin
            right_rows[r*DIM + k] = e[k];
         end
         rows_loaded[r] = 1'b1;
         loads_sent++;
      end else begin
         expected_rows.push_back(predict_product_row(r, e));
         multiplies_sent++;
      end
      @(negedge clock);
   endtask

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
   endtask

   // The receiver draws a fresh wait after every result transfer.
   always @(negedge clock) begin
      if (rsp_took) begin
         rsp_stall_left = draw_wait(rsp_pace);
      end
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker: each transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      product_row_type want;
      elem_type        got;
      rsp_took = 1'b0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_took = 1'b1;
         rows_checked++;
         if (rsp_tuser) begin
            rows_saturated++;
         end
         if (expected_rows.size() == 0) begin
            report_mismatch("result row with nothing outstanding, out_row", 32'd0,
                            32'(rsp_tdata[ROW_W-1:0]));
         end else begin
            want = expected_rows.pop_front();
            if (rsp_tdata[ROW_W-1:0] !== want.row) begin
               report_mismatch("out_row", 32'(want.row), 32'(rsp_tdata[ROW_W-1:0]));
            end
            for (int j = 0; j < DIM; j++) begin
               got = rsp_tdata[ROW_W + ELEM_W*j +: ELEM_W];
               if (got !== want.col[j]) begin
                  report_mismatch($sformatf("row %0d res%0d", want.row, j),
                                  want.col[j], got);
               end
            end
            if (rsp_tuser !== want.ovf) begin
               report_mismatch($sformatf("row %0d overflow", want.row),
                               32'(want.ovf), 32'(rsp_tuser));
            end
         end
      end
   end

   // Element values of mixed magnitude: most random full-range rows would
   // saturate every column, so small Q16.16 numbers make up a good share.
   function automatic elem_type pick_elem();
      case ($urandom_range(0, 9))
         0:       return ELEM_MAX;
         1:       return ELEM_MIN;
         2, 3:    return elem_type'($urandom);
         4:       return '0;
         5, 6:    return elem_type'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         7:       return ($urandom_range(0, 1) == 1) ? elem_type'(32'h0001_0000)
                                                     : elem_type'(-32'sh0001_0000);
         8:       return elem_type'(int'($urandom_range(0, 15)) - 8);
         default: return elem_type'($signed($urandom) >>> $urandom_range(4, 20));
      endcase
   endfunction

   // Identity in Q16.16 must hand each left row back unchanged, the field
   // extremes included.
   task automatic test_identity();
      req_pace = PACE_MIXED;
      rsp_pace = PACE_MIXED;
      send_row(CMD_LOAD, 2'd0, 32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0);
      send_row(CMD_LOAD, 2'd1, 32'sd0, 32'sh0001_0000, 32'sd0, 32'sd0);
      send_row(CMD_LOAD, 2'd2, 32'sd0, 32'sd0, 32'sh0001_0000, 32'sd0);
      send_row(CMD_LOAD, 2'd3, 32'sd0, 32'sd0, 32'sd0, 32'sh0001_0000);
      send_row(CMD_MUL, 2'd0, ELEM_MAX, ELEM_MIN, 32'sd0, -32'sd1);
      send_row(CMD_MUL, 2'd3, 32'sd1, -32'sd1, 32'sh0001_0000, -32'sh0001_0000);
   endtask

   // Saturation both ways, including the sum of four most-negative squares,
   // which does not fit in 64 bits.
   task automatic test_saturation();
      req_pace = PACE_SLOW;
      rsp_pace = PACE_SLOW;
      for (int r = 0; r < DIM; r++) begin
         send_row(CMD_LOAD, row_type'(r), ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
      end
      send_row(CMD_MUL, 2'd1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
      send_row(CMD_MUL, 2'd2, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
      send_row(CMD_MUL, 2'd3, ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX);
   endtask

   // A tiny identity (one raw LSB per diagonal entry) shows the shift
   // truncating toward minus infinity. Rows go back to back so a load is
   // followed at once by a multiply that reads it.
   task automatic test_rounding();
      req_pace = PACE_BURST;
      rsp_pace = PACE_BURST;
      send_row(CMD_LOAD, 2'd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0);
      send_row(CMD_LOAD, 2'd1, 32'sd0, 32'sd1, 32'sd0, 32'sd0);
      send_row(CMD_LOAD, 2'd2, 32'sd0, 32'sd0, 32'sd1, 32'sd0);
      send_row(CMD_LOAD, 2'd3, 32'sd0, 32'sd0, 32'sd0, 32'sd1);
      send_row(CMD_MUL, 2'd2, -32'sd1, 32'sd1, 32'sh0001_7FFF, -32'sh0001_8001);
      send_row(CMD_MUL, 2'd1, ELEM_MIN, ELEM_MAX, -32'sh0001_0000, 32'sh0000_FFFF);
   endtask

   // Random rows, mostly multiplies, with reloads of the right matrix mixed
   // in. The pacing of both sides changes every hundred rows.
   task automatic test_random_rows();
      command_type cmd;
      for (int n = 0; n < RANDOM_ROWS; n++) begin
         if (n % 100 == 0) begin
            req_pace = pace_type'($urandom_range(0, 2));
            rsp_pace = pace_type'($urandom_range(0, 2));
         end
         cmd = ($urandom_range(0, 3) == 0 || rows_loaded != '1) ? CMD_LOAD : CMD_MUL;
         send_row(cmd, row_type'($urandom_range(0, DIM-1)),
                  pick_elem(), pick_elem(), pick_elem(), pick_elem());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_identity();
      test_rounding();
      test_saturation();
      test_random_rows();
      req_tvalid <= 1'b0;

      while (expected_rows.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d load rows and %0d multiply rows sent, %0d result rows checked",
               loads_sent, multiplies_sent, rows_checked);
      $display("summary: %0d result rows saturated, %0d mismatches in %0d cycles",
               rows_saturated, mismatches, cycle_count);
      if (mismatches == 0 && expected_rows.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
